[rtl/core_slot_task_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Core slot task scheduler assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CORE_SLOT_TASK_SCHEDULER_DEFINES_SVH
`define CORE_SLOT_TASK_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/csts_pkg.sv]
// ----------------------------------------------------------------------------
// Core slot task scheduler package
// Field widths, command and result codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package csts_pkg;

   localparam int ACTION_W = 2;
   localparam int TIME_W   = 16;
   localparam int SIDX_W   = 3;
   localparam int KIND_W   = 3;
   localparam int TASK_W   = 16;
   localparam int OCC_W    = 4;
   localparam int WAITC_W  = 5;
   localparam int CORES_W  = 4;

   localparam logic [CORES_W-1:0] CORES_RESET = 4'd8;

   localparam logic [ACTION_W-1:0] ACT_SUBMIT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MOVE    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_QUEUED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_QUEUE_FULL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FINISHED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NONE_FIN   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MOVED      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NONE_MOVED = 3'd5;
   localparam logic [KIND_W-1:0] KIND_REMOVED    = 3'd6;
   localparam logic [KIND_W-1:0] KIND_REFUSED    = 3'd7;

   typedef struct packed {
      logic accept;
      logic count;
      logic snap;
      logic read;
      logic exec;
      logic emit_none;
      logic submit;
      logic rread;
      logic remove;
   } cmd_type;

   typedef struct packed {
      logic idx_end;
      logic all_done;
      logic total_zero;
      logic need_out;
      logic out_free;
   } status_type;

endpackage

[rtl/csts_ifaces.sv]
// ----------------------------------------------------------------------------
// Core slot task scheduler channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface csts_req_if import csts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [TIME_W-1:0]   exec_time;
   logic [SIDX_W-1:0]   slot_index;

   modport source (output valid, output action, output exec_time, output slot_index,
                   input ready);
   modport sink   (input valid, input action, input exec_time, input slot_index,
                   output ready);
endinterface

interface csts_rsp_if import csts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [TASK_W-1:0]  task_id;
   logic [SIDX_W-1:0]  slot;
   logic [OCC_W-1:0]   occupied_count;
   logic [WAITC_W-1:0] waiting_count;
   logic               last;

   modport source (output valid, output kind, output task_id, output slot,
                   output occupied_count, output waiting_count, output last,
                   input ready);
   modport sink   (input valid, input kind, input task_id, input slot,
                   input occupied_count, input waiting_count, input last,
                   output ready);
endinterface

[rtl/csts_controller.sv]
// ----------------------------------------------------------------------------
// Core slot task scheduler controller
// Sequences one request: a counting pass and an update pass over the slots
// for advance and move, or a short fixed sequence for submit and remove.
// ----------------------------------------------------------------------------
module csts_controller import csts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_ready,
   input  status_type          status,
   output cmd_type             cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUB  = 3'd1;
   localparam logic [2:0] ST_RRD  = 3'd2;
   localparam logic [2:0] ST_REX  = 3'd3;
   localparam logic [2:0] ST_CNT  = 3'd4;
   localparam logic [2:0] ST_NONE = 3'd5;
   localparam logic [2:0] ST_RD   = 3'd6;
   localparam logic [2:0] ST_EX   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_action)
                  ACT_SUBMIT: state_in = ST_SUB;
                  ACT_REMOVE: state_in = ST_RRD;
                  default:    state_in = ST_CNT;
               endcase
            end
         end
         ST_SUB: begin
            if (status.out_free) begin
               cmd.submit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_RRD: begin
            cmd.rread = 1'b1;
            state_in  = ST_REX;
         end
         ST_REX: begin
            if (status.out_free) begin
               cmd.remove = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CNT: begin
            if (status.idx_end) begin
               cmd.snap = 1'b1;
               state_in = ST_RD;
            end else begin
               cmd.count = 1'b1;
            end
         end
         ST_NONE: begin
            if (status.out_free) begin
               cmd.emit_none = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_RD: begin
            // Advance's empty result waits for the full walk; move's goes at once.
            if (status.idx_end || status.all_done) begin
               state_in = status.total_zero ? ST_NONE : ST_IDLE;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_EX;
            end
         end
         ST_EX: begin
            // A slot that produces a result waits for room in the output register.
            if (!status.need_out || status.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/csts_datapath.sv]
// ----------------------------------------------------------------------------
// Core slot task scheduler datapath
// Slot table, wait FIFO, id counter, core count register and result register.
// ----------------------------------------------------------------------------
module csts_datapath import csts_pkg::*; #(
   parameter int SLOTS      = 8,
   parameter int WAIT_DEPTH = 16,
   parameter int ID_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CORES_W-1:0]  csr_wr_data,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [TIME_W-1:0]   req_exec_time,
   input  logic [SIDX_W-1:0]   req_slot_index,
   input  cmd_type             cmd,
   output status_type          status,
   csts_rsp_if.source          rsp
);

   localparam int SI_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int WP_W  = $clog2(WAIT_DEPTH);
   localparam int WF_W  = $clog2(WAIT_DEPTH + 1);
   localparam int WE_W  = ID_BITS + TIME_W;

   // Request fields held for the duration of the transaction.
   logic [ACTION_W-1:0] act_ff;
   logic [TIME_W-1:0]   etime_ff;
   logic [SIDX_W-1:0]   sidx_ff;

   logic [CORES_W-1:0]  active_ff;

   // Occupancy and "expires on next advance" flags per slot.
   logic [SLOTS-1:0]    occ_bits_ff;
   logic [SLOTS-1:0]    exp_bits_ff;
   logic [CNT_W-1:0]    occ_cnt_ff;

   logic [ID_BITS-1:0]  slot_id_mem  [SLOTS];
   logic [TIME_W-1:0]   slot_rem_mem [SLOTS];
   logic [ID_BITS-1:0]  rd_id_ff;
   logic [TIME_W-1:0]   rd_rem_ff;

   logic [WE_W-1:0]     wait_mem [WAIT_DEPTH];
   logic [WE_W-1:0]     wq_ff;
   logic [WP_W-1:0]     head_ff;
   logic [WP_W-1:0]     tail_ff;
   logic [WF_W-1:0]     fill_ff;

   logic [ID_BITS-1:0]  next_id_ff;

   logic [CNT_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    total_ff;
   logic [CNT_W-1:0]    emit_cnt_ff;
   logic [CNT_W-1:0]    fin_occ_ff;
   logic [WF_W-1:0]     fin_fill_ff;

   logic                valid_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [TASK_W-1:0]   task_ff;
   logic [SIDX_W-1:0]   slot_ff;
   logic [OCC_W-1:0]    occ_out_ff;
   logic [WAITC_W-1:0]  wait_out_ff;
   logic                last_ff;

   logic [CNT_W-1:0]    used;
   logic [SI_W-1:0]     si;
   logic [SI_W-1:0]     rs;
   logic                idx_end;
   logic                cur_occ;
   logic                cur_exp;
   logic                is_adv;
   logic                fill_nz;
   logic                cnt_inc;
   logic                hit_emit;
   logic                slot_wr;
   logic                id_wr;
   logic [TIME_W-1:0]   rem_wr_data;
   logic [ID_BITS-1:0]  wq_id;
   logic [TIME_W-1:0]   wq_time;
   logic                rem_occ;
   logic                rem_ok;
   logic                full;
   logic [ID_BITS-1:0]  id_inc;
   logic [ID_BITS-1:0]  nid;
   logic                out_free;
   logic                emit;
   logic [SI_W-1:0]     rd_addr;

   assign used = (32'(active_ff) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(active_ff);

   assign si      = idx_ff[SI_W-1:0];
   assign rs      = SI_W'(sidx_ff);
   assign idx_end = (idx_ff == used);
   assign cur_occ = occ_bits_ff[si];
   assign cur_exp = exp_bits_ff[si];
   assign is_adv  = (act_ff == ACT_ADVANCE);
   assign fill_nz = (fill_ff != '0);
   assign wq_id   = wq_ff[WE_W-1:TIME_W];
   assign wq_time = wq_ff[TIME_W-1:0];

   // Move counts free slots only until the queued tasks run out.
   assign cnt_inc  = is_adv ? (cur_occ && cur_exp)
                            : (!cur_occ && (32'(total_ff) < 32'(fill_ff)));
   assign hit_emit = is_adv ? (cur_occ && cur_exp) : (!cur_occ && fill_nz);

   assign id_wr       = cmd.exec && !is_adv && !cur_occ && fill_nz;
   assign slot_wr     = id_wr || (cmd.exec && is_adv && cur_occ && !cur_exp);
   assign rem_wr_data = is_adv ? (rd_rem_ff - TIME_W'(1)) : wq_time;

   assign rem_occ = occ_bits_ff[rs];
   assign rem_ok  = (occ_cnt_ff != '0) && (32'(sidx_ff) < 32'(used));

   assign full   = (32'(fill_ff) >= WAIT_DEPTH);
   assign id_inc = next_id_ff + ID_BITS'(1);
   assign nid    = (id_inc == '0) ? ID_BITS'(1) : id_inc;

   assign out_free = !valid_ff || rsp.ready;
   assign emit     = cmd.emit_none || cmd.submit || cmd.remove || (cmd.exec && hit_emit);
   assign rd_addr  = cmd.rread ? rs : si;

   // Advance walks every slot in use, since slots that do not finish still count down.
   assign status.idx_end    = idx_end;
   assign status.all_done   = !is_adv && (emit_cnt_ff == total_ff);
   assign status.total_zero = (total_ff == '0);
   assign status.need_out   = hit_emit;
   assign status.out_free   = out_free;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= CORES_RESET;
         occ_bits_ff <= '0;
         exp_bits_ff <= '0;
         occ_cnt_ff  <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         next_id_ff  <= '0;
         idx_ff      <= '0;
         total_ff    <= '0;
         emit_cnt_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_wr_data != '0)) begin
            active_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            idx_ff   <= '0;
            total_ff <= '0;
         end
         if (cmd.count && !idx_end) begin
            total_ff <= total_ff + CNT_W'(cnt_inc);
            idx_ff   <= idx_ff + CNT_W'(1);
         end
         if (cmd.snap) begin
            idx_ff      <= '0;
            emit_cnt_ff <= '0;
         end
         if (cmd.exec) begin
            idx_ff <= idx_ff + CNT_W'(1);
            if (hit_emit) begin
               emit_cnt_ff <= emit_cnt_ff + CNT_W'(1);
            end
            if (is_adv) begin
               if (cur_occ && cur_exp) begin
                  occ_bits_ff[si] <= 1'b0;
                  exp_bits_ff[si] <= 1'b0;
                  occ_cnt_ff      <= occ_cnt_ff - CNT_W'(1);
               end else if (cur_occ) begin
                  exp_bits_ff[si] <= (rd_rem_ff <= TIME_W'(2));
               end
            end else if (!cur_occ && fill_nz) begin
               occ_bits_ff[si] <= 1'b1;
               exp_bits_ff[si] <= (wq_time <= TIME_W'(1));
               occ_cnt_ff      <= occ_cnt_ff + CNT_W'(1);
               head_ff         <= (head_ff == WP_W'(WAIT_DEPTH - 1)) ? '0
                                                                     : head_ff + WP_W'(1);
               fill_ff         <= fill_ff - WF_W'(1);
            end
         end
         if (cmd.submit && !full) begin
            tail_ff    <= (tail_ff == WP_W'(WAIT_DEPTH - 1)) ? '0 : tail_ff + WP_W'(1);
            fill_ff    <= fill_ff + WF_W'(1);
            next_id_ff <= nid;
         end
         if (cmd.remove && rem_ok) begin
            occ_bits_ff[rs] <= 1'b0;
            exp_bits_ff[rs] <= 1'b0;
            occ_cnt_ff      <= occ_cnt_ff - CNT_W'(rem_occ);
         end
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Slot table and wait FIFO storage.
   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_rem_mem[si] <= rem_wr_data;
      end
      if (id_wr) begin
         slot_id_mem[si] <= wq_id;
      end
      if (cmd.read || cmd.rread) begin
         rd_id_ff  <= slot_id_mem[rd_addr];
         rd_rem_ff <= slot_rem_mem[rd_addr];
      end
      if (cmd.submit && !full) begin
         wait_mem[tail_ff] <= {nid, etime_ff};
      end
      if (cmd.read) begin
         wq_ff <= wait_mem[head_ff];
      end
   end

   // Held request fields, final counts and the result register.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff   <= req_action;
         etime_ff <= req_exec_time;
         sidx_ff  <= req_slot_index;
      end
      // Every result of a step reports the counts left after the whole step.
      if (cmd.snap) begin
         fin_occ_ff  <= is_adv ? (occ_cnt_ff - total_ff) : (occ_cnt_ff + total_ff);
         fin_fill_ff <= is_adv ? fill_ff : (fill_ff - WF_W'(total_ff));
      end
      if (cmd.exec && hit_emit) begin
         kind_ff     <= is_adv ? KIND_FINISHED : KIND_MOVED;
         task_ff     <= is_adv ? TASK_W'(rd_id_ff) : TASK_W'(wq_id);
         slot_ff     <= SIDX_W'(idx_ff);
         occ_out_ff  <= OCC_W'(fin_occ_ff);
         wait_out_ff <= WAITC_W'(fin_fill_ff);
         last_ff     <= ((emit_cnt_ff + CNT_W'(1)) == total_ff);
      end
      if (cmd.emit_none) begin
         kind_ff     <= is_adv ? KIND_NONE_FIN : KIND_NONE_MOVED;
         task_ff     <= '0;
         slot_ff     <= '0;
         occ_out_ff  <= OCC_W'(occ_cnt_ff);
         wait_out_ff <= WAITC_W'(fill_ff);
         last_ff     <= 1'b1;
      end
      if (cmd.submit) begin
         kind_ff     <= full ? KIND_QUEUE_FULL : KIND_QUEUED;
         task_ff     <= full ? '0 : TASK_W'(nid);
         slot_ff     <= '0;
         occ_out_ff  <= OCC_W'(occ_cnt_ff);
         wait_out_ff <= full ? WAITC_W'(fill_ff) : WAITC_W'(fill_ff + WF_W'(1));
         last_ff     <= 1'b1;
      end
      if (cmd.remove) begin
         kind_ff     <= rem_ok ? KIND_REMOVED : KIND_REFUSED;
         task_ff     <= (rem_ok && rem_occ) ? TASK_W'(rd_id_ff) : '0;
         slot_ff     <= sidx_ff;
         occ_out_ff  <= rem_ok ? OCC_W'(occ_cnt_ff - CNT_W'(rem_occ)) : OCC_W'(occ_cnt_ff);
         wait_out_ff <= WAITC_W'(fill_ff);
         last_ff     <= 1'b1;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.task_id        = task_ff;
   assign rsp.slot           = slot_ff;
   assign rsp.occupied_count = occ_out_ff;
   assign rsp.waiting_count  = wait_out_ff;
   assign rsp.last           = last_ff;

endmodule

[rtl/core_slot_task_scheduler.sv]
// ----------------------------------------------------------------------------
// Core slot task scheduler
// Dispatches queued tasks into core slots and retires them as time advances.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer
//  req_bus   in         valid/ready, one request per transaction
//  rsp_bus   out        valid/ready, one to SLOTS results per request
//  csr_*     in         write enable and 4-bit core count, no handshake
//
//  Submit accepts and then queues the task; remove reads the slot and then frees
//  it. Advance and move count over the slots in use, then visit slots (read, then
//  update); advance visits every slot in use, move stops after its last placement,
//  and an advance or move that yields no task ends with an empty result.
//  Reset clears the slot flags, counters and FIFO pointers.
//  A result that cannot leave the output register holds the slot walk.
// ----------------------------------------------------------------------------
`include "core_slot_task_scheduler_defines.svh"

module core_slot_task_scheduler import csts_pkg::*; #(
   parameter int SLOTS      = 8,
   parameter int WAIT_DEPTH = 16,
   parameter int ID_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CORES_W-1:0] csr_wr_data,
   csts_req_if.sink           req_bus,
   csts_rsp_if.source         rsp_bus
);

   cmd_type    cmd;
   status_type status;

   csts_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   csts_datapath #(
      .SLOTS      (SLOTS),
      .WAIT_DEPTH (WAIT_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_action     (req_bus.action),
      .req_exec_time  (req_bus.exec_time),
      .req_slot_index (req_bus.slot_index),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp_bus)
   );

   `CSTS_ASSERT_IMPL(a_emit_room, clock, reset, (cmd.exec && status.need_out) || cmd.submit || cmd.remove || cmd.emit_none, !rsp_bus.valid || rsp_bus.ready, "result loaded over a pending one")
   `CSTS_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.accept, cmd.count, cmd.snap, cmd.read, cmd.exec, cmd.emit_none, cmd.submit, cmd.rread, cmd.remove}), "more than one command at once")
   `CSTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "request taken while busy")
   `CSTS_ASSERT_IMPL(a_none_is_last, clock, reset, rsp_bus.valid && (rsp_bus.kind == KIND_NONE_FIN || rsp_bus.kind == KIND_NONE_MOVED), rsp_bus.last, "empty result not marked last")

endmodule
